// ===== design/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the texture tile swizzle block.
// ----------------------------------------------------------------------------
package tts_pkg;

  // default strip width in pixels, fixed strip height in rows
  localparam int MAX_WIDTH_DEF = 512;
  localparam int STRIP_ROWS    = 8;
  localparam int ROW_W         = $clog2(STRIP_ROWS);

  // configuration register field widths
  localparam int CFG_W  = 10;
  localparam int IDX_W  = 2;
  localparam int PIX_W  = 32;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_PIXEL_MODE   = 2'd2;

  // command codes of an input item
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // pixel mode codes
  localparam logic MODE_32BIT = 1'b0;
  localparam logic MODE_16BIT = 1'b1;

  typedef struct packed {
    logic             command;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_strip;
    logic             end_of_frame;
  } out_item_t;

  // strip completion event from the write side to the read sequencer
  typedef struct packed {
    logic start;
    logic final_strip;
  } strip_evt_t;

  // per-read metadata travelling with a memory read
  typedef struct packed {
    logic emit;
    logic end_of_strip;
    logic end_of_frame;
    logic mode16;
  } rd_meta_t;

endpackage

// ===== design/tts_stream_if.sv =====
// ----------------------------------------------------------------------------
// tts_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface tts_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/tts_ram.sv =====
// ----------------------------------------------------------------------------
// tts_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tts_write_ctrl.sv =====
// ----------------------------------------------------------------------------
// tts_write_ctrl
// Raster write side: column, row and bank tracking, strip and frame ends.
// ----------------------------------------------------------------------------
module tts_write_ctrl #(
  parameter int MAX_WIDTH = tts_pkg::MAX_WIDTH_DEF,
  parameter int EW        = $clog2(MAX_WIDTH + 1),
  parameter int AW        = $clog2(2 * tts_pkg::STRIP_ROWS * MAX_WIDTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  tts_pkg::in_item_t              item_i,
  input  logic [EW-1:0]                  eff_width_i,
  input  logic [tts_pkg::CFG_W-1:0]      image_height_i,
  input  logic                           pixel_mode_i,
  output logic                           we_o,
  output logic [AW-1:0]                  waddr_o,
  output logic [tts_pkg::PIX_W-1:0]      wdata_o,
  output tts_pkg::strip_evt_t            evt_o,
  output logic                           bank_o
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int BANK_WORDS = tts_pkg::STRIP_ROWS * MAX_WIDTH;
  localparam logic [tts_pkg::ROW_W-1:0] LAST_ROW = tts_pkg::ROW_W'(tts_pkg::STRIP_ROWS - 1);

  logic [COL_W-1:0]          col_q, col_d;
  logic [tts_pkg::ROW_W-1:0] row_q, row_d;
  logic [tts_pkg::CFG_W-1:0] rows_q, rows_d;
  logic                      bank_q, bank_d;

  logic [EW-1:0]             col_full, col_inc;
  logic [COL_W-1:0]          col;
  logic [tts_pkg::CFG_W-1:0] rows_inc;
  logic                      do_write, row_end, strip_end, frame_end;

  // clamp the column to the current row length
  always_comb begin
    col_full  = (EW'(col_q) < eff_width_i) ? EW'(col_q) : eff_width_i - EW'(1);
    col       = col_full[COL_W-1:0];
    col_inc   = col_full + EW'(1);
    rows_inc  = rows_q + tts_pkg::CFG_W'(1);
    do_write  = accept_i && (item_i.command == tts_pkg::CMD_PIXEL) && (eff_width_i != '0);
    row_end   = col_inc >= eff_width_i;
    strip_end = row_end && (row_q == LAST_ROW);
    frame_end = row_end && (rows_inc >= image_height_i);
  end

  // next position after one stored pixel
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    rows_d = rows_q;
    bank_d = bank_q;
    if (do_write) begin
      col_d = row_end ? '0 : col_inc[COL_W-1:0];
      if (row_end) begin
        row_d  = row_q + tts_pkg::ROW_W'(1);
        rows_d = rows_inc;
      end
      if (strip_end) begin
        bank_d = ~bank_q;
      end
      if (frame_end) begin
        rows_d = '0;
        row_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rows_q <= '0;
      bank_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      rows_q <= rows_d;
      bank_q <= bank_d;
    end
  end

  // memory write into the current bank
  assign we_o    = do_write;
  assign waddr_o = (bank_q ? AW'(BANK_WORDS) : AW'(0))
                 + AW'(row_q) * AW'(MAX_WIDTH) + AW'(col);
  assign wdata_o = (pixel_mode_i == tts_pkg::MODE_16BIT)
                 ? {16'h0000, item_i.pixel_in[15:0]} : item_i.pixel_in;

  // strip completion, final when the next strip would not fit the frame
  assign evt_o.start       = do_write && strip_end;
  assign evt_o.final_strip = ({1'b0, rows_inc} + 11'd8) > {1'b0, image_height_i};
  assign bank_o            = bank_q;

`ifndef SYNTH
  a_frame_end_clears_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write && frame_end |=> (rows_q == '0) && (row_q == '0))
    else $error("frame end did not clear row counters");
  a_strip_flips_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.start |=> bank_q != $past(bank_q))
    else $error("strip completion did not swap banks");
`endif

endmodule

// ===== design/tts_read_ctrl.sv =====
// ----------------------------------------------------------------------------
// tts_read_ctrl
// Tiled read sequencer: walks a finished strip tile by tile.
// ----------------------------------------------------------------------------
module tts_read_ctrl #(
  parameter int MAX_WIDTH = tts_pkg::MAX_WIDTH_DEF,
  parameter int EW        = $clog2(MAX_WIDTH + 1),
  parameter int AW        = $clog2(2 * tts_pkg::STRIP_ROWS * MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [EW-1:0]         eff_width_i,
  input  logic                  pixel_mode_i,
  input  tts_pkg::strip_evt_t   evt_i,
  input  logic                  write_bank_i,
  output logic [AW-1:0]         raddr_o,
  output tts_pkg::rd_meta_t     meta_o
);

  localparam int POS_W      = $clog2(tts_pkg::STRIP_ROWS * MAX_WIDTH + 1);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int BANK_WORDS = tts_pkg::STRIP_ROWS * MAX_WIDTH;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             active_q, active_d;
  logic             final_q, final_d;

  logic [EW-1:0]             eff_tiles;
  logic [POS_W-1:0]          span, pos_inc, tile_base;
  logic [tts_pkg::ROW_W-1:0] row;
  logic [COL_W-1:0]          col;
  logic                      mode16, emit, last;

  // span of whole tiles and tile coordinates of the read position
  always_comb begin
    mode16    = pixel_mode_i == tts_pkg::MODE_16BIT;
    eff_tiles = mode16 ? (eff_width_i & ~EW'(7)) : (eff_width_i & ~EW'(3));
    span      = POS_W'(eff_tiles) << 3;
    pos_inc   = pos_q + POS_W'(1);
    emit      = active_q && (pos_q < span);
    last      = pos_inc == span;
    tile_base = pos_q >> 3;
    if (mode16) begin
      row = pos_q[5:3];
      col = COL_W'((tile_base & ~POS_W'(7)) | POS_W'(pos_q[2:0]));
    end else begin
      row = pos_q[4:2];
      col = COL_W'((tile_base & ~POS_W'(3)) | POS_W'(pos_q[1:0]));
    end
  end

  // address in the bank that is not being written
  assign raddr_o = (!write_bank_i ? AW'(BANK_WORDS) : AW'(0))
                 + AW'(row) * AW'(MAX_WIDTH) + AW'(col);

  assign meta_o.emit         = emit;
  assign meta_o.end_of_strip = last;
  assign meta_o.end_of_frame = last && final_q;
  assign meta_o.mode16       = mode16;

  // advance on every transaction, a completed strip restarts the walk
  always_comb begin
    pos_d    = pos_q;
    active_d = active_q;
    final_d  = final_q;
    if (accept_i) begin
      if (emit) begin
        pos_d = pos_inc;
      end
      active_d = emit && !last;
      if (evt_i.start) begin
        pos_d    = '0;
        active_d = span != '0;
        final_d  = evt_i.final_strip;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      active_q <= 1'b0;
      final_q  <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      active_q <= active_d;
      final_q  <= final_d;
    end
  end

`ifndef SYNTH
  a_restart_at_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && evt_i.start |=> pos_q == '0)
    else $error("strip start did not restart the read walk");
  a_last_stops_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && emit && last && !evt_i.start |=> !active_q)
    else $error("read stayed active past the end of strip");
`endif

endmodule

// ===== design/tts_out_buf.sv =====
// ----------------------------------------------------------------------------
// tts_out_buf
// Read-data stage and output register: two-deep pipeline with backpressure.
// ----------------------------------------------------------------------------
module tts_out_buf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  output logic                      accept_o,
  output logic                      ram_re_o,
  input  tts_pkg::rd_meta_t         meta_i,
  input  logic [tts_pkg::PIX_W-1:0] rdata_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tts_pkg::out_item_t        out_data_o
);

  logic               s1_valid_q, s1_valid_d;
  tts_pkg::rd_meta_t  s1_meta_q;
  logic               out_valid_q, out_valid_d;
  tts_pkg::out_item_t out_data_q;
  logic               s1_adv;

  // stage 1 holds the memory read register, it moves on when the output frees
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept_o   = in_valid_i && in_ready_o;
  assign ram_re_o   = accept_o && meta_i.emit;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_o) begin
      s1_valid_d = meta_i.emit;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ram_re_o) begin
      s1_meta_q <= meta_i;
    end
    if (s1_adv) begin
      out_data_q.pixel_out    <= s1_meta_q.mode16 ? {16'h0000, rdata_i[15:0]} : rdata_i;
      out_data_q.end_of_strip <= s1_meta_q.end_of_strip;
      out_data_q.end_of_frame <= s1_meta_q.end_of_frame;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_no_read_over_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |-> (!s1_valid_q || s1_adv))
    else $error("memory read overwrote a held read result");
`endif

endmodule

// ===== design/texture_tile_swizzle.sv =====
// ----------------------------------------------------------------------------
// texture_tile_swizzle
// Raster to tiled reorder of texture pixels through a ping-pong strip memory.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle, pixel or drain, while the output is
// not stalled, set by the single write port and single read port of the strip memory.
// Result path: a result read by a transaction passes the memory read register,
// then the output register.
// Reset: control state and configuration clear to zero at once; the strip
// memory is not cleared and needs no clearing pass.
module texture_tile_swizzle #(
  parameter int MAX_WIDTH = tts_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tts_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [tts_pkg::CFG_W-1:0] cfg_data_i,
  tts_stream_if.sink                in_i,
  tts_stream_if.source              out_o
);

  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (EW > tts_pkg::CFG_W) ? EW : tts_pkg::CFG_W;
  localparam int DEPTH = 2 * tts_pkg::STRIP_ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  logic [tts_pkg::CFG_W-1:0] width_q, height_q;
  logic                      mode_q;
  logic [EW-1:0]             eff_width;

  logic                      accept, ram_re, ram_we;
  logic [AW-1:0]             raddr, waddr;
  logic [tts_pkg::PIX_W-1:0] wdata, rdata;
  tts_pkg::strip_evt_t       evt;
  tts_pkg::rd_meta_t         meta;
  logic                      write_bank;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      mode_q   <= tts_pkg::MODE_32BIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tts_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        tts_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        tts_pkg::CFG_PIXEL_MODE:   mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // row length saturates at the strip width
  assign eff_width = (CW'(width_q) > CW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(width_q);

  tts_write_ctrl #(.MAX_WIDTH(MAX_WIDTH), .EW(EW), .AW(AW)) u_write (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (in_i.data),
    .eff_width_i    (eff_width),
    .image_height_i (height_q),
    .pixel_mode_i   (mode_q),
    .we_o           (ram_we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .evt_o          (evt),
    .bank_o         (write_bank)
  );

  tts_read_ctrl #(.MAX_WIDTH(MAX_WIDTH), .EW(EW), .AW(AW)) u_read (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .eff_width_i  (eff_width),
    .pixel_mode_i (mode_q),
    .evt_i        (evt),
    .write_bank_i (write_bank),
    .raddr_o      (raddr),
    .meta_o       (meta)
  );

  // reads and writes always target opposite banks, no forwarding needed
  tts_ram #(.WIDTH(tts_pkg::PIX_W), .DEPTH(DEPTH), .AW(AW)) u_strip_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tts_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .accept_o    (accept),
    .ram_re_o    (ram_re),
    .meta_i      (meta),
    .rdata_i     (rdata),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

`ifndef SYNTH
  a_no_bank_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> waddr != raddr)
    else $error("read and write hit the same strip entry");
`endif

endmodule

// ===== verif/texture_tile_swizzle_tb.sv =====
// ----------------------------------------------------------------------------
// texture_tile_swizzle_tb
// Streams raster pixels and drain transactions into the swizzle block under
// a series of width, height and pixel mode settings, and compares every
// tiled output pixel and its strip and frame flags with a cycle-free
// predictor of the strip memory reorder. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module texture_tile_swizzle_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W       = tts_pkg::MAX_WIDTH_DEF;
  localparam int unsigned ROWS        = tts_pkg::STRIP_ROWS;
  localparam int unsigned BANK_WORDS  = ROWS * MAX_W;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [tts_pkg::IDX_W-1:0] cfg_idx_i;
  logic [tts_pkg::CFG_W-1:0] cfg_data_i;

  tts_stream_if #(.payload_t(tts_pkg::in_item_t))  in_if ();
  tts_stream_if #(.payload_t(tts_pkg::out_item_t)) out_if ();

  texture_tile_swizzle dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // pending raster transactions and tiled pixels still owed by the block
  tts_pkg::in_item_t  raster_q[$];
  tts_pkg::out_item_t tiled_q[$];
  int unsigned        raster_count;
  int unsigned        cycle_count;
  int                 error_count;
  bit                 idle_on;
  bit                 in_accepted;
  int unsigned        in_gap;
  int unsigned        ready_hold;

  // predictor copy of settings and strip memory state
  logic [tts_pkg::CFG_W-1:0] cfg_width;
  logic [tts_pkg::CFG_W-1:0] cfg_height;
  logic                      cfg_mode;
  logic [tts_pkg::PIX_W-1:0] strip_mem [2*BANK_WORDS];
  int unsigned               wr_col;
  int unsigned               wr_row;
  int unsigned               rows_seen;
  logic                      wr_bank;
  int unsigned               rd_pos;
  bit                        rd_busy;
  bit                        rd_last_strip;
  int unsigned               rd_bank_width;

  function automatic int unsigned row_len();
    return (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
  endfunction

  function automatic int unsigned tile_w();
    return (cfg_mode == tts_pkg::MODE_16BIT) ? 8 : 4;
  endfunction

  function automatic int unsigned tile_span();
    return (row_len() / tile_w()) * tile_w() * ROWS;
  endfunction

  // one transaction through the reorder: read side first, then write side
  task automatic swizzle_step(input tts_pkg::in_item_t item);
    int unsigned               w;
    int unsigned               span;
    int unsigned               tw;
    int unsigned               tile;
    int unsigned               inner;
    int unsigned               row;
    int unsigned               col;
    logic [tts_pkg::PIX_W-1:0] px;
    tts_pkg::out_item_t        res;
    w = row_len();
    if (rd_busy) begin
      span = tile_span();
      if (rd_pos >= span) begin
        rd_busy = 1'b0;
      end else begin
        tw    = tile_w();
        tile  = rd_pos / (tw * ROWS);
        inner = rd_pos % (tw * ROWS);
        row   = inner / tw;
        col   = tile * tw + inner % tw;
        px    = strip_mem[(wr_bank ? 0 : BANK_WORDS) + row * MAX_W + col];
        if (cfg_mode == tts_pkg::MODE_16BIT) px = {16'h0, px[15:0]};
        res.pixel_out    = px;
        res.end_of_strip = (rd_pos + 1 == span);
        res.end_of_frame = res.end_of_strip && rd_last_strip;
        tiled_q.push_back(res);
        rd_pos++;
        if (res.end_of_strip) rd_busy = 1'b0;
      end
    end
    if (item.command == tts_pkg::CMD_PIXEL && w != 0) begin
      px  = item.pixel_in;
      if (cfg_mode == tts_pkg::MODE_16BIT) px = {16'h0, px[15:0]};
      col = (wr_col < w) ? wr_col : w - 1;
      row = wr_row % ROWS;
      strip_mem[(wr_bank ? BANK_WORDS : 0) + row * MAX_W + col] = px;
      wr_col = col + 1;
      if (wr_col >= w) begin
        wr_col    = 0;
        wr_row    = row + 1;
        rows_seen = (rows_seen + 1) & 32'h3FF;
        // full strip: swap banks and start reading it out
        if (wr_row >= ROWS) begin
          wr_row        = 0;
          wr_bank       = ~wr_bank;
          rd_pos        = 0;
          rd_busy       = (tile_span() != 0);
          rd_last_strip = (rows_seen + ROWS > cfg_height);
          rd_bank_width = w;
        end
        if (rows_seen >= cfg_height) begin
          rows_seen = 0;
          wr_row    = 0;
        end
      end
    end
  endtask

  // idle lengths: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [tts_pkg::PIX_W-1:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic push_pixel();
    tts_pkg::in_item_t item;
    item.command  = tts_pkg::CMD_PIXEL;
    item.pixel_in = pick_pixel();
    raster_q.push_back(item);
    raster_count++;
  endtask

  task automatic push_drain();
    tts_pkg::in_item_t item;
    item.command  = tts_pkg::CMD_DRAIN;
    item.pixel_in = $urandom;
    raster_q.push_back(item);
    raster_count++;
  endtask

  // wait until every transaction is in and every tiled pixel is out
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (raster_q.size() != 0 || in_if.valid || tiled_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [tts_pkg::IDX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[tts_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    unique case (idx)
      tts_pkg::CFG_IMAGE_WIDTH:  cfg_width  = value[tts_pkg::CFG_W-1:0];
      tts_pkg::CFG_IMAGE_HEIGHT: cfg_height = value[tts_pkg::CFG_W-1:0];
      tts_pkg::CFG_PIXEL_MODE:   cfg_mode   = value[0];
      default: ;
    endcase
  endtask

  // one setting: realign, reprogram, stream rows, then drain the read
  task automatic run_phase(input int unsigned width, input int unsigned height,
                           input logic mode, input int unsigned rows, input bit flush);
    int unsigned w_new;
    int unsigned trunc_new;
    int unsigned w;
    int unsigned n;
    int unsigned rows_left;
    w_new     = (width > MAX_W) ? MAX_W : width;
    trunc_new = (mode == tts_pkg::MODE_16BIT) ? (w_new / 8) * 8 : (w_new / 4) * 4;
    // complete a partial strip or frame under the old settings
    while (wr_col != 0 || wr_row != 0) begin
      w         = row_len();
      rows_left = (cfg_height > rows_seen) ? cfg_height - rows_seen : 1;
      if (rows_left > ROWS - wr_row) rows_left = ROWS - wr_row;
      n = rows_left * w - wr_col;
      repeat (n) push_pixel();
      wait_idle();
    end
    // a pending read may carry over only if it stays inside written columns
    while (rd_busy && trunc_new > rd_bank_width) begin
      n = (tile_span() > rd_pos) ? tile_span() - rd_pos : 1;
      repeat (n) push_drain();
      wait_idle();
    end
    write_cfg(tts_pkg::CFG_IMAGE_WIDTH, width);
    write_cfg(tts_pkg::CFG_IMAGE_HEIGHT, height);
    write_cfg(tts_pkg::CFG_PIXEL_MODE, int'(mode));
    // raster rows with drains mixed in
    w = row_len();
    if (w == 0) repeat (3) push_pixel();
    repeat (rows) begin
      repeat (w) begin
        if ($urandom_range(0, 19) == 0) push_drain();
        push_pixel();
      end
    end
    // now and then a row cut short
    if (w > 1 && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, w - 1)) push_pixel();
    wait_idle();
    if (rd_busy) begin
      n = (tile_span() > rd_pos) ? tile_span() - rd_pos : 1;
      if (!flush) n = $urandom_range(0, n);
      repeat (n) push_drain();
      wait_idle();
    end
  endtask

  // raster driver
  always @(negedge clk_i) begin
    if (in_if.valid && !in_accepted) begin
      // hold the offered transaction
    end else begin
      in_accepted = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (raster_q.size() > 0) begin
        in_if.data  <= raster_q.pop_front();
        in_if.valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output stalls
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
    end
  end

  // accepted transactions feed the predictor, results are checked in order
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        swizzle_step(in_if.data);
        in_accepted = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        if (tiled_q.size() == 0) begin
          $error("unexpected output pixel_out %h", out_if.data.pixel_out);
          error_count++;
        end else begin
          if (out_if.data.pixel_out !== tiled_q[0].pixel_out) begin
            $error("pixel_out: expected %h, actual %h",
                   tiled_q[0].pixel_out, out_if.data.pixel_out);
            error_count++;
          end
          if (out_if.data.end_of_strip !== tiled_q[0].end_of_strip) begin
            $error("end_of_strip: expected %b, actual %b",
                   tiled_q[0].end_of_strip, out_if.data.end_of_strip);
            error_count++;
          end
          if (out_if.data.end_of_frame !== tiled_q[0].end_of_frame) begin
            $error("end_of_frame: expected %b, actual %b",
                   tiled_q[0].end_of_frame, out_if.data.end_of_frame);
            error_count++;
          end
          void'(tiled_q.pop_front());
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned phase_no;
    int unsigned r;
    int unsigned width;
    int unsigned height;
    int unsigned rows;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    cfg_width     = '0;
    cfg_height    = '0;
    cfg_mode      = tts_pkg::MODE_32BIT;
    wr_col        = 0;
    wr_row        = 0;
    rows_seen     = 0;
    wr_bank       = 1'b0;
    rd_pos        = 0;
    rd_busy       = 1'b0;
    rd_last_strip = 1'b0;
    rd_bank_width = 0;
    idle_on       = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: drain with nothing pending, zero width, one small strip,
    // width below one tile, short frame, 16-bit pixels over two strips
    push_drain();
    wait_idle();
    run_phase(0, 0, tts_pkg::MODE_32BIT, 1, 1'b1);
    run_phase(4, 8, tts_pkg::MODE_32BIT, 8, 1'b1);
    run_phase(3, 8, tts_pkg::MODE_32BIT, 8, 1'b1);
    run_phase(4, 5, tts_pkg::MODE_32BIT, 6, 1'b1);
    run_phase(8, 16, tts_pkg::MODE_16BIT, 16, 1'b1);

    // random settings, with a few single-row frames wider than the strip
    raster_count = 0;
    phase_no     = 0;
    while (raster_count < 2000) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase_no == 4) begin
        run_phase(1023, 1, tts_pkg::MODE_16BIT, 1, 1'b1);
      end else if (phase_no == 8) begin
        run_phase(513, 1, tts_pkg::MODE_32BIT, 1, 1'b0);
      end else if (phase_no == 12) begin
        run_phase(4, 512, tts_pkg::MODE_32BIT, 24, 1'b1);
      end else begin
        r      = $urandom_range(0, 9);
        width  = (r == 0) ? $urandom_range(0, 3) :
                 (r < 3)  ? $urandom_range(4, 16) : $urandom_range(1, 40);
        height = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 40);
        rows   = $urandom_range(0, 20);
        while (rows > 1 && rows * width > 600) rows--;
        run_phase(width, height, logic'($urandom_range(0, 1)), rows,
                  ($urandom_range(0, 3) != 0));
      end
      phase_no++;
    end

    wait_idle();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
